/* rtl/xte_pkg.sv */
package xte_pkg;

	// escape class of one source character
	typedef enum logic [2:0] {
		XTE_PLAIN,
		XTE_AMP,
		XTE_LT,
		XTE_GT,
		XTE_QUOT,
		XTE_APOS,
		XTE_CTRL
	} xte_kind_t;

	// one classified character handed from front end to back end
	typedef struct packed {
		logic [7:0] ch;
		xte_kind_t  kind;
		logic       run_end;
		logic       text_end;
	} xte_job_t;

	// classification result plus next pass-through flag
	typedef struct packed {
		xte_kind_t kind;
		logic      raw;
	} xte_cls_t;

	localparam int XTE_QDEPTH = 4;
	localparam int XTE_QPTR_W = $clog2(XTE_QDEPTH);

	localparam logic [7:0] CTRL_LIMIT = 8'd32;

	// index of the final output character of a class
	function automatic logic [2:0] xte_last_idx(input xte_kind_t kind);
		logic [2:0] r;
		unique case (kind)
			XTE_PLAIN: r = 3'd0;
			XTE_AMP:   r = 3'd4;
			XTE_LT:    r = 3'd3;
			XTE_GT:    r = 3'd3;
			XTE_QUOT:  r = 3'd5;
			XTE_APOS:  r = 3'd5;
			XTE_CTRL:  r = 3'd5;
			default:   r = 3'd0;
		endcase
		return r;
	endfunction

	// uppercase hex digit
	function automatic logic [7:0] xte_hex(input logic [3:0] v);
		logic [7:0] r;
		if (v < 4'd10) begin
			r = 8'h30 + {4'd0, v};
		end else begin
			r = 8'h37 + {4'd0, v};
		end
		return r;
	endfunction

	// output character number idx of the escaped form
	function automatic logic [7:0] xte_char(input xte_kind_t kind, input logic [2:0] idx,
			input logic [7:0] ch);
		logic [7:0] r;
		r = ch;
		unique case (kind)
			XTE_PLAIN: r = ch;
			XTE_AMP: begin
				unique case (idx)
					3'd0: r = "&";
					3'd1: r = "a";
					3'd2: r = "m";
					3'd3: r = "p";
					default: r = ";";
				endcase
			end
			XTE_LT: begin
				unique case (idx)
					3'd0: r = "&";
					3'd1: r = "l";
					3'd2: r = "t";
					default: r = ";";
				endcase
			end
			XTE_GT: begin
				unique case (idx)
					3'd0: r = "&";
					3'd1: r = "g";
					3'd2: r = "t";
					default: r = ";";
				endcase
			end
			XTE_QUOT: begin
				unique case (idx)
					3'd0: r = "&";
					3'd1: r = "q";
					3'd2: r = "u";
					3'd3: r = "o";
					3'd4: r = "t";
					default: r = ";";
				endcase
			end
			XTE_APOS: begin
				unique case (idx)
					3'd0: r = "&";
					3'd1: r = "a";
					3'd2: r = "p";
					3'd3: r = "o";
					3'd4: r = "s";
					default: r = ";";
				endcase
			end
			XTE_CTRL: begin
				unique case (idx)
					3'd0: r = "&";
					3'd1: r = "#";
					3'd2: r = "x";
					3'd3: r = xte_hex(ch[7:4]);
					3'd4: r = xte_hex(ch[3:0]);
					default: r = ";";
				endcase
			end
			default: r = ch;
		endcase
		return r;
	endfunction

endpackage

/* rtl/xte_if.sv */
// input word channel
interface xte_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// output word channel
interface xte_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_end;
	logic       text_end;

	modport source (output valid, output out_byte, output run_end, output text_end,
		input ready);
	modport sink (input valid, input out_byte, input run_end, input text_end,
		output ready);
endinterface

/* rtl/xte_front.sv */
module xte_front
	import xte_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	xte_in_if.sink   text_in,
	input  logic     full,
	output logic     push,
	output xte_job_t job
);

	logic [7:0] win_q [3];
	logic [7:0] win_d [3];
	logic [1:0] cnt_q, cnt_d;
	logic       raw_q, raw_d;
	logic       flush_q, flush_d;
	logic       acc;
	xte_cls_t   cls;

	// decide pass-through or escape class for one character
	function automatic xte_cls_t classify(input logic raw, input logic [7:0] c,
			input logic last, input logic ok, input logic [7:0] n1, input logic [7:0] n2);
		xte_cls_t r;
		logic     esc;
		r.raw  = raw;
		r.kind = XTE_PLAIN;
		esc    = 1'b1;
		if (raw) begin
			if (c != ";" && !last) begin
				esc = 1'b0;
			end else begin
				r.raw = 1'b0;
			end
		end else if (c == "&" && ok && n1 == "#" && n2 == "x") begin
			r.raw = 1'b1;
			esc   = 1'b0;
		end
		if (esc) begin
			priority if (c == "&") begin
				r.kind = XTE_AMP;
			end else if (c == "<") begin
				r.kind = XTE_LT;
			end else if (c == ">") begin
				r.kind = XTE_GT;
			end else if (c == 8'h22) begin
				r.kind = XTE_QUOT;
			end else if (c == 8'h27) begin
				r.kind = XTE_APOS;
			end else if (c < CTRL_LIMIT) begin
				r.kind = XTE_CTRL;
			end else begin
				r.kind = XTE_PLAIN;
			end
		end
		return r;
	endfunction

	// no new word while draining the window at string end or while the job queue is full
	assign text_in.ready = !flush_q && !full;
	assign acc           = text_in.valid && text_in.ready;

	// window update and job generation
	always_comb begin
		cnt_d   = cnt_q;
		raw_d   = raw_q;
		flush_d = flush_q;
		win_d   = win_q;
		push    = 1'b0;
		job     = '0;
		cls     = '0;
		if (flush_q) begin
			if (!full) begin
				cls          = classify(raw_q, win_q[0], cnt_q == 2'd1, cnt_q == 2'd3,
					win_q[1], win_q[2]);
				push         = 1'b1;
				job.ch       = win_q[0];
				job.kind     = cls.kind;
				job.run_end  = (cnt_q == 2'd1);
				job.text_end = (cnt_q == 2'd1);
				raw_d        = cls.raw;
				win_d[0]     = win_q[1];
				win_d[1]     = win_q[2];
				cnt_d        = cnt_q - 2'd1;
				if (cnt_q == 2'd1) begin
					flush_d = 1'b0;
					raw_d   = 1'b0;
				end
			end
		end else if (acc) begin
			if (text_in.in_last) begin
				win_d[cnt_q] = text_in.in_byte;
				cnt_d        = cnt_q + 2'd1;
				flush_d      = 1'b1;
			end else if (cnt_q != 2'd2) begin
				win_d[cnt_q] = text_in.in_byte;
				cnt_d        = cnt_q + 2'd1;
			end else begin
				cls         = classify(raw_q, win_q[0], 1'b0, 1'b1, win_q[1],
					text_in.in_byte);
				push        = 1'b1;
				job.ch      = win_q[0];
				job.kind    = cls.kind;
				job.run_end = 1'b1;
				raw_d       = cls.raw;
				win_d[0]    = win_q[1];
				win_d[1]    = text_in.in_byte;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			raw_q   <= 1'b0;
			flush_q <= 1'b0;
		end else begin
			cnt_q   <= cnt_d;
			raw_q   <= raw_d;
			flush_q <= flush_d;
		end
	end

	// lookahead window
	always_ff @(posedge clk) begin
		win_q <= win_d;
	end

endmodule

/* rtl/xte_fifo.sv */
module xte_fifo
	import xte_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  xte_job_t wr_job,
	input  logic     pop,
	output logic     full,
	output logic     empty,
	output xte_job_t head
);

	xte_job_t              mem_q [XTE_QDEPTH];
	logic [XTE_QPTR_W-1:0] wr_ptr_q;
	logic [XTE_QPTR_W-1:0] rd_ptr_q;
	logic [XTE_QPTR_W:0]   count_q;

	assign full  = (count_q == (XTE_QPTR_W+1)'(XTE_QDEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

/* rtl/xte_back.sv */
module xte_back
	import xte_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     empty,
	input  xte_job_t head,
	output logic     pop,
	xte_out_if.source text_out
);

	logic [2:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       run_end_q;
	logic       text_end_q;
	logic       step;
	logic       lastc;

	// one output word per cycle from the queue head while it is not empty and the sink is ready
	assign step  = !empty && (!valid_q || text_out.ready);
	assign lastc = (idx_q == xte_last_idx(head.kind));
	assign pop   = step && lastc;

	assign text_out.valid    = valid_q;
	assign text_out.out_byte = byte_q;
	assign text_out.run_end  = run_end_q;
	assign text_out.text_end = text_end_q;

	// character counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else if (step) begin
			valid_q <= 1'b1;
			idx_q   <= lastc ? 3'd0 : idx_q + 3'd1;
		end else if (text_out.ready) begin
			valid_q <= 1'b0;
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (step) begin
			byte_q     <= xte_char(head.kind, idx_q, head.ch);
			run_end_q  <= head.run_end && lastc;
			text_end_q <= head.text_end && lastc;
		end
	end

endmodule

/* rtl/xml_text_escape_encoder.sv */
// Streaming XML text escaper. Input words carry one string byte each, with in_last on the
// final byte; output words carry one byte of escaped text, with run_end on the last word
// caused by an input word and text_end on the final word of the string. Output lags input
// by two bytes of lookahead, so the first two bytes of a string produce nothing until a
// third arrives or the string ends. The back end emits exactly one output word per cycle
// while the job queue is not empty and the sink is ready; an input byte yields as many
// output words as its escaped form has bytes: 1 for a plain or pass-through byte, 4 for
// &lt; and &gt;, 5 for &amp;, 6 for &quot;, &apos; and &#xHH;. The front end takes a new
// byte every cycle while the four-entry job queue has room; on the last byte of a string
// it drains its held bytes (up to three) into the queue before it takes the next string.
module xml_text_escape_encoder
	import xte_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	xte_in_if.sink    text_in,
	xte_out_if.source text_out
);

	logic     full;
	logic     empty;
	logic     push;
	logic     pop;
	xte_job_t job;
	xte_job_t head;

	// window, classification and pass-through tracking
	xte_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.text_in (text_in),
		.full    (full),
		.push    (push),
		.job     (job)
	);

	// job queue between the two halves
	xte_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (job),
		.pop    (pop),
		.full   (full),
		.empty  (empty),
		.head   (head)
	);

	// expansion into output words
	xte_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.head     (head),
		.pop      (pop),
		.text_out (text_out)
	);

	// queue never overflows
	assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("job pushed into full queue");

	// queue never underflows
	assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("job popped from empty queue");

	// end of string always closes an input word's run
	assert property (@(posedge clk) disable iff (!arst_n)
		text_out.valid && text_out.text_end |-> text_out.run_end)
		else $error("text_end without run_end");

	// a popped job that ends a run shows run_end on the next output word
	assert property (@(posedge clk) disable iff (!arst_n)
		pop && head.run_end |=> text_out.valid && text_out.run_end)
		else $error("run end lost on final word of a job");

endmodule

/* test/tb.sv */
module tb
	import xte_pkg::*;
();

	localparam int RANDOM_ITEMS = 250;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int TAIL_CYCLES = 30;
	localparam int SOURCE_SIDE = 0;
	localparam int SINK_SIDE = 1;

	// one escaped output word as the block should present it
	typedef struct packed {
		logic [7:0] ch;
		logic       run_end;
		logic       text_end;
	} out_word_t;

	// one row of the directed stimulus
	typedef struct {
		logic [7:0] b;
		logic       last;
		bit         typed;
		string      txt;
	} text_row_t;

	logic clk = 1'b0;
	logic arst_n;

	xte_in_if  text_in();
	xte_out_if text_out();

	xml_text_escape_encoder u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.text_in  (text_in),
		.text_out (text_out)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// escaper state: two-byte lookahead window and pass-through flag
	logic [7:0] win_bytes [2];
	int         win_count;
	bit         in_raw_run;

	logic [7:0] escaped_bytes [$];
	out_word_t  expected_words [$];
	text_row_t  directed_rows [$];

	int  error_count;
	int  cycle_count;
	int  calm_left [2];
	int  sink_stall;
	bit  draining;

	// gap length: mostly short, a few long, with calm stretches of none
	function automatic int pick_gap(input int side);
		int r;
		if (calm_left[side] > 0) begin
			calm_left[side]--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			calm_left[side] = $urandom_range(10, 40);
		end
		if (r < 55) begin
			return 0;
		end
		if (r < 85) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) begin
			return 8'h30 + {4'd0, v};
		end
		return 8'h41 + {4'd0, v} - 8'd10;
	endfunction

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			escaped_bytes.push_back(s[i]);
		end
	endtask

	// escape one source byte; n1 and n2 are the bytes that follow it
	task automatic escape_char(input logic [7:0] c, input bit at_end, input bit look_ok,
			input logic [7:0] n1, input logic [7:0] n2);
		if (in_raw_run) begin
			if (c != ";" && !at_end) begin
				escaped_bytes.push_back(c);
				return;
			end
			in_raw_run = 1'b0;
		end else if (c == "&" && look_ok && n1 == "#" && n2 == "x") begin
			in_raw_run = 1'b1;
			escaped_bytes.push_back(c);
			return;
		end
		case (c)
			"&":  push_text("&amp;");
			"<":  push_text("&lt;");
			">":  push_text("&gt;");
			"\"": push_text("&quot;");
			"'":  push_text("&apos;");
			default: begin
				if (c < CTRL_LIMIT) begin
					push_text("&#x");
					escaped_bytes.push_back(hex_char(c[7:4]));
					escaped_bytes.push_back(hex_char(c[3:0]));
					escaped_bytes.push_back(";");
				end else begin
					escaped_bytes.push_back(c);
				end
			end
		endcase
	endtask

	// advance the window by one input word, leaving its output in escaped_bytes
	task automatic escape_step(input logic [7:0] b, input logic last);
		logic [7:0] seq [3];
		int total;
		bit ok;
		escaped_bytes.delete();
		if (!last) begin
			if (win_count < 2) begin
				win_bytes[win_count] = b;
				win_count++;
				return;
			end
			escape_char(win_bytes[0], 1'b0, 1'b1, win_bytes[1], b);
			win_bytes[0] = win_bytes[1];
			win_bytes[1] = b;
		end else begin
			// flush held bytes and the new one in order
			for (int k = 0; k < win_count; k++) begin
				seq[k] = win_bytes[k];
			end
			seq[win_count] = b;
			total = win_count + 1;
			for (int k = 0; k < total; k++) begin
				ok = (k + 2) < total;
				escape_char(seq[k], k + 1 == total, ok, ok ? seq[k + 1] : 8'd0,
					ok ? seq[k + 2] : 8'd0);
			end
			win_count = 0;
			in_raw_run = 1'b0;
		end
	endtask

	// queue the expected words of an accepted input word
	task automatic record_input(input logic [7:0] b, input logic last, input bit typed,
			input string txt);
		out_word_t w;
		int n;
		escape_step(b, last);
		if (typed) begin
			escaped_bytes.delete();
			push_text(txt);
		end
		n = escaped_bytes.size();
		for (int i = 0; i < n; i++) begin
			w.ch = escaped_bytes[i];
			w.run_end = (i == n - 1);
			w.text_end = last && (i == n - 1);
			expected_words.push_back(w);
		end
	endtask

	// present one input word and wait for it to be taken
	task automatic send_word(input logic [7:0] b, input logic last, input bit typed,
			input string txt);
		int gap;
		gap = pick_gap(SOURCE_SIDE);
		if (gap > 0) begin
			text_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_in.valid <= 1'b1;
		text_in.in_byte <= b;
		text_in.in_last <= last;
		@(posedge clk);
		while (!text_in.ready) begin
			@(posedge clk);
		end
		record_input(b, last, typed, txt);
	endtask

	// hold the sender off until every expected word has come out
	task automatic wait_for_quiet();
		text_in.valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (expected_words.size() != 0);
	endtask

	task automatic add_row(input logic [7:0] b, input logic last, input bit typed,
			input string txt);
		text_row_t r;
		r.b = b;
		r.last = last;
		r.typed = typed;
		r.txt = txt;
		directed_rows.push_back(r);
	endtask

	function automatic logic [7:0] random_text_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			case ($urandom_range(0, 5))
				0: return "&";
				1: return "<";
				2: return ">";
				3: return "\"";
				4: return "'";
				default: return ";";
			endcase
		end
		if (r < 45) begin
			return 8'($urandom_range(0, 31));
		end
		if (r < 80) begin
			return 8'($urandom_range(32, 126));
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// sink readiness with random stalls, held high while draining
	always @(posedge clk) begin
		if (sink_stall > 0 && !draining) begin
			text_out.ready <= 1'b0;
			sink_stall <= sink_stall - 1;
		end else begin
			text_out.ready <= 1'b1;
			sink_stall <= pick_gap(SINK_SIDE);
		end
	end

	// compare each output word with the oldest expectation
	always @(posedge clk) begin : output_check
		out_word_t want;
		if (arst_n && text_out.valid && text_out.ready) begin
			if (expected_words.size() == 0) begin
				error_count++;
				if (error_count <= 10) begin
					$display("unexpected word at %0t: out_byte %h run_end %b text_end %b",
						$time, text_out.out_byte, text_out.run_end, text_out.text_end);
				end
			end else begin
				want = expected_words.pop_front();
				if (text_out.out_byte !== want.ch || text_out.run_end !== want.run_end ||
						text_out.text_end !== want.text_end) begin
					error_count++;
					if (error_count <= 10) begin
						$display("word error at %0t: want %h/%b/%b got %h/%b/%b", $time,
							want.ch, want.run_end, want.text_end, text_out.out_byte,
							text_out.run_end, text_out.text_end);
					end
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		logic [7:0] text_buf [$];
		int sent;
		int want_len;
		int r;
		int n;
		bit paused;

		arst_n = 1'b0;
		text_in.valid = 1'b0;
		text_in.in_byte = 8'd0;
		text_in.in_last = 1'b0;
		text_out.ready = 1'b0;
		win_count = 0;
		in_raw_run = 1'b0;
		error_count = 0;
		cycle_count = 0;
		sink_stall = 0;
		draining = 1'b0;
		calm_left[SOURCE_SIDE] = 0;
		calm_left[SINK_SIDE] = 0;
		sent = 0;
		paused = 1'b0;

		// control byte extremes, space, top byte, each named entity
		add_row(8'h00, 1'b1, 1'b1, "&#x00;");
		add_row(8'h1F, 1'b1, 1'b1, "&#x1F;");
		add_row(8'h20, 1'b1, 1'b1, " ");
		add_row(8'hFF, 1'b1, 1'b0, "");
		add_row("&", 1'b1, 1'b1, "&amp;");
		add_row("<", 1'b0, 1'b1, "");
		add_row(">", 1'b0, 1'b1, "");
		add_row("\"", 1'b1, 1'b1, "&lt;&gt;&quot;");
		add_row("'", 1'b1, 1'b1, "&apos;");
		// pass-through run closed by a semicolon
		add_row("&", 1'b0, 1'b1, "");
		add_row("#", 1'b0, 1'b1, "");
		add_row("x", 1'b0, 1'b1, "&");
		add_row(8'h7F, 1'b0, 1'b0, "");
		add_row("&", 1'b0, 1'b0, "");
		add_row(";", 1'b0, 1'b0, "");
		add_row("Z", 1'b1, 1'b0, "");
		// ampersand too close to the end to start a run
		add_row("&", 1'b0, 1'b1, "");
		add_row("#", 1'b1, 1'b1, "&amp;#");
		// run started on the final flush, closed by the last byte
		add_row("&", 1'b0, 1'b1, "");
		add_row("#", 1'b0, 1'b1, "");
		add_row("x", 1'b1, 1'b1, "&#x");
		// near miss: ampersand hash but no x
		add_row("&", 1'b0, 1'b1, "");
		add_row("#", 1'b0, 1'b1, "");
		add_row("y", 1'b0, 1'b1, "&amp;");
		add_row(8'h0A, 1'b1, 1'b1, "#y&#x0A;");

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_word(directed_rows[i].b, directed_rows[i].last, directed_rows[i].typed,
				directed_rows[i].txt);
		end
		wait_for_quiet();

		// random strings, many with character references well formed or broken
		while (sent < RANDOM_ITEMS) begin
			text_buf.delete();
			r = $urandom_range(0, 99);
			if (r < 70) begin
				want_len = $urandom_range(1, 6);
			end else if (r < 95) begin
				want_len = $urandom_range(7, 15);
			end else begin
				want_len = $urandom_range(16, 30);
			end
			while (text_buf.size() < want_len) begin
				if ($urandom_range(0, 99) < 15) begin
					text_buf.push_back("&");
					text_buf.push_back("#");
					text_buf.push_back("x");
					n = $urandom_range(0, 4);
					repeat (n) begin
						if ($urandom_range(0, 3) != 0) begin
							text_buf.push_back(hex_char(4'($urandom_range(0, 15))));
						end else begin
							text_buf.push_back(random_text_byte());
						end
					end
					if ($urandom_range(0, 4) != 0) begin
						text_buf.push_back(";");
					end
				end else begin
					text_buf.push_back(random_text_byte());
				end
			end
			foreach (text_buf[i]) begin
				send_word(text_buf[i], i == text_buf.size() - 1, 1'b0, "");
			end
			sent += text_buf.size();
			if (!paused && sent >= RANDOM_ITEMS / 2) begin
				paused = 1'b1;
				wait_for_quiet();
			end
		end

		// drain and let any stray words show up
		text_in.valid <= 1'b0;
		draining <= 1'b1;
		do begin
			@(posedge clk);
		end while (expected_words.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
